@@ rtl/idunp_pkg.sv @@
// shared constants and types of the packed identifier unpacker
package idunp_pkg;

  localparam int ID_BITS_DEF    = 40;
  localparam int WORD_BITS_DEF  = 64;
  localparam int OFFSET_BITS    = 6;
  localparam int COUNT_BITS     = 32;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_START_OFFSET = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ID_COUNT     = CFG_INDEX_BITS'(1);

  // per-word job handed from front to back
  typedef struct packed {
    logic two;   // job carries two identifiers
    logic fin;   // last identifier of the job completes the read
  } idunp_ctl_t;

endpackage

@@ rtl/idunp_front.sv @@
// front end: gathers word bits, cuts identifiers and tracks read progress
module idunp_front #(
  parameter int ID_BITS   = idunp_pkg::ID_BITS_DEF,
  parameter int WORD_BITS = idunp_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [WORD_BITS-1:0]               word,
  input  logic [idunp_pkg::OFFSET_BITS-1:0]  start_offset,
  input  logic [idunp_pkg::COUNT_BITS-1:0]   id_count,
  output logic                               push,
  output logic [ID_BITS-1:0]                 id_a,
  output logic [ID_BITS-1:0]                 id_b,
  output idunp_pkg::idunp_ctl_t              ctl
);
  import idunp_pkg::*;

  localparam int XW = (WORD_BITS > ID_BITS) ? WORD_BITS : ID_BITS;
  localparam int SW = $clog2(WORD_BITS + ID_BITS + 1);
  localparam int LW = $clog2(ID_BITS + 1);
  localparam int OW = OFFSET_BITS + 1;

  logic [ID_BITS-1:0]    leftover_bits;
  logic [LW-1:0]         leftover_count;
  logic [COUNT_BITS-1:0] emitted_count;
  logic                  first_word_pending;

  logic [SW-1:0]         pos0;
  logic [SW-1:0]         avail1;
  logic [SW-1:0]         need1;
  logic [SW-1:0]         pos2;
  logic [SW-1:0]         avail2;
  logic                  have1;
  logic                  have2;
  logic [XW-1:0]         wx1;
  logic [XW-1:0]         wx2;
  logic [ID_BITS-1:0]    comb1;
  logic                  fin1;
  logic                  fin2;
  logic                  active;

  always_comb begin
    if ({1'b0, start_offset} > OW'(WORD_BITS)) begin
      pos0 = SW'(WORD_BITS);
    end else begin
      pos0 = SW'(start_offset);
    end
    if (!first_word_pending) begin
      pos0 = '0;
    end
    avail1 = SW'(WORD_BITS) - pos0;
    need1  = SW'(ID_BITS) - SW'(leftover_count);
    have1  = avail1 >= need1;
    wx1    = XW'(word) >> pos0;
    // leftover holds only its low bits, so one or serves both the cut and the gather
    comb1  = ID_BITS'((XW'(leftover_bits)) | (wx1 << leftover_count));
    pos2   = pos0 + need1;
    avail2 = SW'(WORD_BITS) - pos2;
    have2  = avail2 >= SW'(ID_BITS);
    wx2    = XW'(word) >> pos2;
    fin1   = ({1'b0, emitted_count} + (COUNT_BITS + 1)'(1)) >= {1'b0, id_count};
    fin2   = ({1'b0, emitted_count} + (COUNT_BITS + 1)'(2)) >= {1'b0, id_count};
    active = accept && (id_count != '0);
  end

  always_comb begin
    push    = active && have1;
    id_a    = comb1;
    id_b    = ID_BITS'(wx2);
    ctl.two = !fin1 && have2;
    ctl.fin = fin1 || (have2 && fin2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits      <= '0;
      leftover_count     <= '0;
      emitted_count      <= '0;
      first_word_pending <= 1'b1;
    end else if (active) begin
      first_word_pending <= 1'b0;
      if (!have1) begin
        leftover_bits  <= comb1;
        leftover_count <= LW'(SW'(leftover_count) + avail1);
      end else if (fin1) begin
        leftover_bits      <= '0;
        leftover_count     <= '0;
        emitted_count      <= '0;
        first_word_pending <= 1'b1;
      end else if (!have2) begin
        emitted_count  <= emitted_count + COUNT_BITS'(1);
        leftover_bits  <= ID_BITS'(wx2);
        leftover_count <= LW'(avail2);
      end else begin
        // two identifiers out of this word, any bits past the second are dropped
        leftover_bits  <= '0;
        leftover_count <= '0;
        if (fin2) begin
          emitted_count      <= '0;
          first_word_pending <= 1'b1;
        end else begin
          emitted_count <= emitted_count + COUNT_BITS'(2);
        end
      end
    end
  end

endmodule

@@ rtl/idunp_queue.sv @@
// two-entry job queue between front and back
module idunp_queue #(
  parameter int ID_BITS = idunp_pkg::ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [ID_BITS-1:0]    push_id_a,
  input  logic [ID_BITS-1:0]    push_id_b,
  input  idunp_pkg::idunp_ctl_t push_ctl,
  input  logic                  pop,
  output logic [ID_BITS-1:0]    head_id_a,
  output logic [ID_BITS-1:0]    head_id_b,
  output idunp_pkg::idunp_ctl_t head_ctl,
  output logic                  not_empty,
  output logic                  full,
  output logic [1:0]            fill
);
  import idunp_pkg::*;

  logic [ID_BITS-1:0] ids_a [2];
  logic [ID_BITS-1:0] ids_b [2];
  idunp_ctl_t         ctls  [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign head_id_a = ids_a[rd_ptr];
  assign head_id_b = ids_b[rd_ptr];
  assign head_ctl  = ctls[rd_ptr];
  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;
  assign fill      = count;

  always_ff @(posedge clk) begin
    if (push) begin
      ids_a[wr_ptr] <= push_id_a;
      ids_b[wr_ptr] <= push_id_b;
      ctls[wr_ptr]  <= push_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/idunp_back.sv @@
// back end: plays jobs out one identifier per cycle through the output register while out_ready is high
module idunp_back #(
  parameter int ID_BITS = idunp_pkg::ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ID_BITS-1:0]    head_id_a,
  input  logic [ID_BITS-1:0]    head_id_b,
  input  idunp_pkg::idunp_ctl_t head_ctl,
  input  logic                  not_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_BITS-1:0]    particle_id,
  output logic                  last_of_word,
  output logic                  final_of_read
);
  import idunp_pkg::*;

  logic               pend_valid;
  logic [ID_BITS-1:0] pend_id;
  logic               pend_fin;
  logic               load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend_valid && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid     <= 1'b1;
        particle_id   <= pend_id;
        last_of_word  <= 1'b1;
        final_of_read <= pend_fin;
        pend_valid    <= 1'b0;
      end else if (not_empty) begin
        out_valid     <= 1'b1;
        particle_id   <= head_id_a;
        last_of_word  <= !head_ctl.two;
        final_of_read <= !head_ctl.two && head_ctl.fin;
        // second identifier of the word waits in the pending register
        pend_valid    <= head_ctl.two;
        pend_id       <= head_id_b;
        pend_fin      <= head_ctl.fin;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/packed_id_unpacker_40_from_64.sv @@
// top level of the packed identifier unpacker
//
// words of packed identifiers (lsb first) come in on in_valid/in_ready, each
// finished identifier leaves on out_valid/out_ready with last_of_word and
// final_of_read. start_bit_offset (index 0) and id_count (index 1) are written
// on the cfg channel, which is always ready; write them while the block is idle.
// a word is cut in the cycle it is accepted; its first identifier goes through the
// job queue and then the output register, and a second one, if any, through the
// pending register after it. the output register gives one identifier per cycle
// while out_ready is high, so a word that yields two identifiers plays out both
// before the next job is popped from the queue.
// a two-entry job queue sits between the cutting front and the output side;
// when the receiver stalls the queue fills and in_ready drops once it is full.
// reset empties the queue and output, clears the leftover bits and progress and
// arms the start offset; both registers reset to zero and while id_count is zero
// words are taken and ignored.
module packed_id_unpacker_40_from_64 #(
  parameter int ID_BITS   = idunp_pkg::ID_BITS_DEF,
  parameter int WORD_BITS = idunp_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [WORD_BITS-1:0]                 packed_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ID_BITS-1:0]                   particle_id,
  output logic                                 last_of_word,
  output logic                                 final_of_read,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [idunp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [idunp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import idunp_pkg::*;

  logic [OFFSET_BITS-1:0] start_bit_offset;
  logic [COUNT_BITS-1:0]  id_count;

  logic               accept;
  logic               q_push;
  logic [ID_BITS-1:0] push_id_a;
  logic [ID_BITS-1:0] push_id_b;
  idunp_ctl_t         push_ctl;
  logic               q_pop;
  logic [ID_BITS-1:0] head_id_a;
  logic [ID_BITS-1:0] head_id_b;
  idunp_ctl_t         head_ctl;
  logic               q_not_empty;
  logic               q_full;
  logic [1:0]         q_fill;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_bit_offset <= '0;
      id_count         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_OFFSET: start_bit_offset <= cfg_data[OFFSET_BITS-1:0];
        REG_ID_COUNT:     id_count         <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  idunp_front #(
    .ID_BITS  (ID_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .word        (packed_word),
    .start_offset(start_bit_offset),
    .id_count    (id_count),
    .push        (q_push),
    .id_a        (push_id_a),
    .id_b        (push_id_b),
    .ctl         (push_ctl)
  );

  idunp_queue #(
    .ID_BITS(ID_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_id_a(push_id_a),
    .push_id_b(push_id_b),
    .push_ctl (push_ctl),
    .pop      (q_pop),
    .head_id_a(head_id_a),
    .head_id_b(head_id_b),
    .head_ctl (head_ctl),
    .not_empty(q_not_empty),
    .full     (q_full),
    .fill     (q_fill)
  );

  idunp_back #(
    .ID_BITS(ID_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_id_a    (head_id_a),
    .head_id_b    (head_id_b),
    .head_ctl     (head_ctl),
    .not_empty    (q_not_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .particle_id  (particle_id),
    .last_of_word (last_of_word),
    .final_of_read(final_of_read)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_fill != 2'd2)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_fill != 2'd0)
    else $error("job queue read while empty");

  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_of_read) |-> last_of_word)
    else $error("final identifier not marked last of its word");

  a_zero_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && id_count == '0) |-> !q_push)
    else $error("job produced while the count is zero");

endmodule
